// ===== hdl/ldrwbf_pkg.sv =====
package ldrwbf_pkg;

  // One BGRA pixel packed with blue in the lowest byte.
  typedef logic [31:0] px_t;

  // One window column, element 0 is the oldest row.
  typedef px_t [4:0] col_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_GAIN         = 2'd2
  } cfg_idx_e;

  // Normalizing divisor 5*5*255*3*255 and its reciprocal scaled by 2**RECIP_SHIFT.
  localparam logic [22:0] LDR_DIVISOR = 23'd4876875;
  localparam logic [17:0] LDR_RECIP   = 18'd225454;
  localparam int unsigned RECIP_SHIFT = 40;

  // Channel limits.
  localparam logic [7:0] CHAN_MAX = 8'd255;

  // Stage loads for the channel lanes.
  typedef struct packed {
    logic ld_v;
    logic ld_r;
    logic ld_q;
  } lane_ctl_t;

endpackage

// ===== hdl/ldrwbf_ram.sv =====
module ldrwbf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port, registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ldrwbf_cell.sv =====
module ldrwbf_cell
  import ldrwbf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        shift_i,
  input  col_t        col_i,
  output col_t        col_o,
  output logic [11:0] sum_o
);

  col_t        col_q;
  logic [11:0] sum_q;
  logic [11:0] sum_d;

  // Sum of blue, green and red over the incoming column.
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < 5; k++) begin
      sum_d = sum_d + 12'(col_i[k][7:0]) + 12'(col_i[k][15:8]) + 12'(col_i[k][23:16]);
    end
  end

  // The column moves one place along the chain on every shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      sum_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
      sum_q <= sum_d;
    end
  end

  assign col_o = col_q;
  assign sum_o = sum_q;

endmodule

// ===== hdl/ldrwbf_lane.sv =====
module ldrwbf_lane
  import ldrwbf_pkg::*;
(
  input  logic               clk_i,
  input  lane_ctl_t          ctl_i,
  input  logic signed [23:0] gs_i,
  input  logic [7:0]         chan_i,
  output logic [7:0]         res_o
);

  logic [7:0]         c_q;
  logic signed [31:0] v_q;
  logic signed [31:0] v_d;
  logic signed [31:0] gs_ext;
  logic signed [31:0] c_ext;
  logic [30:0]        m_d;
  logic [30:0]        m_q;
  logic               neg_q;
  logic [48:0]        p_d;
  logic [7:0]         q0_q;
  logic [30:0]        qd_d;
  logic [31:0]        rem_d;
  logic [8:0]         q_q;
  logic [8:0]         q_d;
  logic signed [10:0] r_d;

  // Gain times window sum times channel.
  assign gs_ext = 32'(gs_i);
  assign c_ext  = $signed({24'd0, chan_i});
  assign v_d    = gs_ext * c_ext;

  // Magnitude and reciprocal estimate, low by at most one.
  assign m_d = v_q[31] ? 31'(-v_q) : v_q[30:0];
  assign p_d = 49'(m_d) * 49'(LDR_RECIP);

  // Correct the estimate with one multiply and compare.
  assign qd_d  = 31'(q0_q) * 31'(LDR_DIVISOR);
  assign rem_d = {1'b0, m_q} - {1'b0, qd_d};
  assign q_d   = {1'b0, q0_q} + ((rem_d >= 32'(LDR_DIVISOR)) ? 9'd1 : 9'd0);

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_v) begin
      c_q <= chan_i;
      v_q <= v_d;
    end
    if (ctl_i.ld_r) begin
      m_q   <= m_d;
      neg_q <= v_q[31];
      q0_q  <= p_d[RECIP_SHIFT+7:RECIP_SHIFT];
    end
    if (ctl_i.ld_q) begin
      q_q <= q_d;
    end
  end

  // Quotient truncates toward zero, then the sum is clamped to a byte.
  assign r_d = neg_q ? ($signed({3'b0, c_q}) - $signed({2'b0, q_q}))
                     : ($signed({3'b0, c_q}) + $signed({2'b0, q_q}));

  always_comb begin
    if (r_d < 0) begin
      res_o = '0;
    end else if (r_d > $signed({3'b0, CHAN_MAX})) begin
      res_o = CHAN_MAX;
    end else begin
      res_o = r_d[7:0];
    end
  end

endmodule

// ===== hdl/ldr_window_brightness_filter_core.sv =====
// Channel   | Direction | Handshake                    | Payload
// s_axis    | in        | s_axis_tvalid, s_axis_tready | tdata pixel, tuser opcode
// m_axis    | out       | m_axis_tvalid, m_axis_tready | tdata pixel, tlast frame end
// cfg       | in        | cfg_valid_i, cfg_ready_o     | cfg_index_i, cfg_data_i
//
// A pixel that yields a result is walked by the sequencer through the line buffer
// read, the window shift and the five arithmetic steps; one that yields no result
// skips the arithmetic steps, and an ignored flush skips the read as well.
// After any configuration write the first item waits while a bit-serial divider
// rebuilds the output row and column.
// Reset clears counters, the window and the sequencer; the line buffer is not cleared.
// A full output register holds the sequencer in its last step until m_axis_tready.
module ldr_window_brightness_filter_core
  import ldrwbf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // in_blue, in_green, in_red, in_alpha
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_blue, out_green, out_red, out_alpha
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  localparam int unsigned COLW = $clog2(MAX_WIDTH);
  localparam int unsigned EWW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EHW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned ROWW = $clog2(MAX_HEIGHT + 4);
  localparam int unsigned CNTW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned NW   = $clog2((MAX_HEIGHT + 4) * MAX_WIDTH);
  localparam int unsigned DCW  = $clog2(CNTW);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_DIV  = 11'b00000000010,
    S_MUL  = 11'b00000000100,
    S_CHK  = 11'b00000001000,
    S_RD   = 11'b00000010000,
    S_SUM  = 11'b00000100000,
    S_GAIN = 11'b00001000000,
    S_VMUL = 11'b00010000000,
    S_REC  = 11'b00100000000,
    S_QCOR = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [11:0]       cfg_w_q;
  logic [12:0]       cfg_h_q;
  logic signed [8:0] gain_q;
  logic              rediv_q;

  logic [EWW-1:0] eff_w;
  logic [EHW-1:0] eff_h;

  logic [ROWW-1:0] in_row_q;
  logic [COLW-1:0] in_col_q;
  logic [CNTW-1:0] out_cnt_q;
  logic [EHW-1:0]  out_row_q;
  logic [COLW-1:0] out_col_q;

  logic [CNTW-1:0] total_q;
  logic [NW-1:0]   rowoff_q;
  logic [NW-1:0]   n_d;
  logic            clr_d;
  logic            need_out_q;
  logic            flush_q;
  px_t             in_px_q;
  px_t             px_q;
  logic [COLW-1:0] rd_addr;

  logic [EWW:0]    div_rem_q;
  logic [CNTW-1:0] div_quo_q;
  logic [DCW-1:0]  div_cnt_q;
  logic [EWW:0]    div_sh;
  logic            div_ge;

  px_t [3:0]   bank_rd;
  col_t        col_in;
  col_t [4:0]  cell_col;
  logic [11:0] cell_sum [5];
  logic [14:0] winsum_q;
  logic signed [23:0] gs_q;
  logic signed [23:0] g_ext;
  logic signed [23:0] ws_ext;
  lane_ctl_t   lane_ctl;
  logic [7:0]  lane_res [3];
  px_t         src;
  logic        interior;
  logic        last_d;
  logic        obuf_free;

  logic        obuf_v_q;
  px_t         obuf_q;
  logic        obuf_last_q;

  // Frame sizes in use, held to the supported range.
  always_comb begin
    if (cfg_w_q == '0) begin
      eff_w = EWW'(1);
    end else if (32'(cfg_w_q) > MAX_WIDTH) begin
      eff_w = EWW'(MAX_WIDTH);
    end else begin
      eff_w = EWW'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      eff_h = EHW'(1);
    end else if (32'(cfg_h_q) > MAX_HEIGHT) begin
      eff_h = EHW'(MAX_HEIGHT);
    end else begin
      eff_h = EHW'(cfg_h_q);
    end
  end

  // Configuration registers; a write also schedules the row and column rebuild.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= 12'd640;
      cfg_h_q <= 13'd480;
      gain_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  cfg_w_q <= cfg_data_i[11:0];
        CFG_FRAME_HEIGHT: cfg_h_q <= cfg_data_i;
        CFG_GAIN:         gain_q  <= $signed(cfg_data_i[8:0]);
        default: ;
      endcase
    end
  end

  // Position checks for the item in hand.
  assign clr_d   = (out_cnt_q >= total_q) || (32'(in_col_q) >= 32'(eff_w));
  assign n_d     = clr_d ? '0 : rowoff_q + NW'(in_col_q);
  assign rd_addr = clr_d ? '0 : in_col_q;

  // Restoring divider step for the output row and column.
  assign div_sh = {div_rem_q[EWW-1:0], div_quo_q[CNTW-1]};
  assign div_ge = div_sh >= {1'b0, eff_w};

  // Output position and the end of the frame.
  assign interior = (out_row_q >= EHW'(2)) && (32'(out_row_q) + 3 <= 32'(eff_h)) &&
                    (out_col_q >= COLW'(2)) && (32'(out_col_q) + 3 <= 32'(eff_w));
  assign last_d    = (out_cnt_q + CNTW'(1)) >= total_q;
  assign obuf_free = !obuf_v_q || m_axis_tready;

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (rediv_q) begin
          state_d = S_DIV;
        end else if (s_axis_tvalid) begin
          state_d = S_MUL;
        end
      end
      S_DIV:  if (div_cnt_q == DCW'(CNTW - 1)) state_d = S_IDLE;
      S_MUL:  state_d = S_CHK;
      S_CHK: begin
        if ((NW'(total_q) > n_d) && flush_q) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD:   state_d = need_out_q ? S_SUM : S_IDLE;
      S_SUM:  state_d = S_GAIN;
      S_GAIN: state_d = S_VMUL;
      S_VMUL: state_d = S_REC;
      S_REC:  state_d = S_QCOR;
      S_QCOR: state_d = S_OUT;
      S_OUT:  if (obuf_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE) && !rediv_q;

  // Sequencer and frame counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rediv_q   <= 1'b0;
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_cnt_q <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      div_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        rediv_q <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          div_cnt_q <= '0;
        end
        S_DIV: begin
          div_cnt_q <= div_cnt_q + DCW'(1);
          if (div_cnt_q == DCW'(CNTW - 1)) begin
            // A write in the final step of the rebuild asks for another pass.
            if (!cfg_valid_i) begin
              rediv_q <= 1'b0;
            end
            out_row_q <= EHW'({div_quo_q[CNTW-2:0], div_ge});
            out_col_q <= div_ge ? COLW'(div_sh - {1'b0, eff_w}) : COLW'(div_sh);
          end
        end
        S_CHK: begin
          if (clr_d) begin
            in_row_q  <= '0;
            in_col_q  <= '0;
            out_cnt_q <= '0;
            out_row_q <= '0;
            out_col_q <= '0;
          end
        end
        S_RD: begin
          if (32'(in_col_q) + 1 >= 32'(eff_w)) begin
            in_col_q <= '0;
            in_row_q <= in_row_q + ROWW'(1);
          end else begin
            in_col_q <= in_col_q + COLW'(1);
          end
        end
        S_OUT: begin
          if (obuf_free) begin
            if (last_d) begin
              in_row_q  <= '0;
              in_col_q  <= '0;
              out_cnt_q <= '0;
              out_row_q <= '0;
              out_col_q <= '0;
            end else begin
              out_cnt_q <= out_cnt_q + CNTW'(1);
              if (32'(out_col_q) + 1 >= 32'(eff_w)) begin
                out_col_q <= '0;
                out_row_q <= out_row_q + EHW'(1);
              end else begin
                out_col_q <= out_col_q + COLW'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_px_q <= s_axis_tdata;
      flush_q <= s_axis_tuser;
    end
    if (state_q == S_IDLE) begin
      div_rem_q <= '0;
      div_quo_q <= out_cnt_q;
    end
    if (state_q == S_DIV) begin
      div_rem_q <= div_ge ? (div_sh - {1'b0, eff_w}) : div_sh;
      div_quo_q <= {div_quo_q[CNTW-2:0], div_ge};
    end
    if (state_q == S_MUL) begin
      total_q  <= CNTW'(eff_w) * CNTW'(eff_h);
      rowoff_q <= NW'(in_row_q) * NW'(eff_w);
    end
    if (state_q == S_CHK) begin
      px_q       <= (NW'(total_q) > n_d) ? in_px_q : '0;
      need_out_q <= n_d >= (NW'({eff_w, 1'b0}) + NW'(2));
    end
    if (state_q == S_SUM) begin
      winsum_q <= 15'(cell_sum[0]) + 15'(cell_sum[1]) + 15'(cell_sum[2]) +
                  15'(cell_sum[3]) + 15'(cell_sum[4]);
    end
    if (state_q == S_GAIN) begin
      gs_q <= g_ext * ws_ext;
    end
  end

  assign g_ext  = 24'(gain_q);
  assign ws_ext = $signed({9'd0, winsum_q});

  // Four line buffer rows, all read at the same column.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    ldrwbf_ram #(
      .WIDTH(32),
      .DEPTH(MAX_WIDTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   ((state_q == S_RD) && (in_row_q[1:0] == 2'(b))),
      .waddr_i(in_col_q),
      .wdata_i(px_q),
      .raddr_i(rd_addr),
      .rdata_o(bank_rd[b])
    );
  end

  // New window column: four stored rows, oldest first, then the current pixel.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      col_in[k] = bank_rd[2'(in_row_q[1:0] + 2'(k))];
    end
    col_in[4] = px_q;
  end

  // Chain of five column cells; the newest column enters at cell four.
  for (genvar j = 0; j < 5; j++) begin : g_cell
    ldrwbf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(state_q == S_RD),
      .col_i  ((j == 4) ? col_in : cell_col[(j == 4) ? 4 : j + 1]),
      .col_o  (cell_col[j]),
      .sum_o  (cell_sum[j])
    );
  end

  assign src = cell_col[2][2];

  // Boost lanes for blue, green and red.
  assign lane_ctl.ld_v = (state_q == S_VMUL);
  assign lane_ctl.ld_r = (state_q == S_REC);
  assign lane_ctl.ld_q = (state_q == S_QCOR);

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    ldrwbf_lane u_lane (
      .clk_i (clk_i),
      .ctl_i (lane_ctl),
      .gs_i  (gs_q),
      .chan_i(src[8*ch +: 8]),
      .res_o (lane_res[ch])
    );
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obuf_v_q <= 1'b0;
    end else if ((state_q == S_OUT) && obuf_free) begin
      obuf_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      obuf_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_OUT) && obuf_free) begin
      obuf_last_q <= last_d;
      if (interior) begin
        obuf_q <= {src[31:24], lane_res[2], lane_res[1], lane_res[0]};
      end else begin
        obuf_q <= src;
      end
    end
  end

  assign m_axis_tvalid = obuf_v_q;
  assign m_axis_tdata  = obuf_q;
  assign m_axis_tlast  = obuf_last_q;

endmodule
